>>> src/tpds_pkg.sv
// Package for the timer prescaler and divisor search.
// Holds the item types and the fixed clock and timing constants.
// Used by tpds_cell and timer_prescaler_divisor_search.
package tpds_pkg;

   localparam logic [23:0] BASE_CLK_HZ = 24'd13560000;
   localparam logic [19:0] US_PER_S    = 20'd1000000;
   localparam logic [12:0] RECIP_US    = 13'd4294;
   localparam logic [27:0] PROD_LIMIT  = 28'd255000000;
   localparam int          DIV_STEPS   = 4;

   typedef struct packed {
      logic        found;
      logic [4:0]  exp;
      logic [7:0]  div;
      logic [19:0] excess;
   } best_type;

   typedef struct packed {
      logic [31:0] t;
      best_type    best;
   } item_type;

   typedef struct packed {
      item_type   item;
      logic       ok;
      logic [7:0] div;
   } cell_sb_type;

endpackage

>>> src/tpds_divider.sv
// Pipelined restoring divider with a side channel that travels with each quotient.
// Retires up to SPS quotient bits per stage; no package dependencies.
module tpds_divider #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 8,
   parameter int SPS   = 4,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [SB_W-1:0]  out_sb
);
   localparam int NSTG = (NUM_W + SPS - 1) / SPS;

   logic             valid_ff [NSTG];
   logic [DEN_W-1:0] rem_ff   [NSTG];
   logic [NUM_W-1:0] nq_ff    [NSTG];
   logic [DEN_W-1:0] den_ff   [NSTG];
   logic [SB_W-1:0]  sb_ff    [NSTG];
   logic [DEN_W-1:0] rem_in   [NSTG];
   logic [NUM_W-1:0] nq_in    [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : g_stage
      logic             valid_src;
      logic [DEN_W-1:0] rem_src;
      logic [NUM_W-1:0] nq_src;
      logic [DEN_W-1:0] den_src;
      logic [SB_W-1:0]  sb_src;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign nq_src    = in_num;
         assign den_src   = in_den;
         assign sb_src    = in_sb;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign nq_src    = nq_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign sb_src    = sb_ff[s-1];
      end

      always_comb begin : p_steps
         logic [DEN_W:0]   tmp;
         logic [DEN_W-1:0] r;
         logic [NUM_W-1:0] q;
         r   = rem_src;
         q   = nq_src;
         tmp = '0;
         for (int k = 0; k < SPS; k++) begin
            if (s * SPS + k < NUM_W) begin
               tmp = {r, q[NUM_W-1]};
               q   = {q[NUM_W-2:0], 1'b0};
               if (tmp >= {1'b0, den_src}) begin
                  tmp  = tmp - {1'b0, den_src};
                  q[0] = 1'b1;
               end
               r = tmp[DEN_W-1:0];
            end
         end
         rem_in[s] = r;
         nq_in[s]  = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            nq_ff[s]  <= nq_in[s];
            den_ff[s] <= den_src;
            sb_ff[s]  <= sb_src;
         end
      end
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_quo   = nq_ff[NSTG-1];
   assign out_sb    = sb_ff[NSTG-1];

endmodule

>>> src/tpds_cell.sv
// One prescaler cell of the search chain: evaluates one exponent and updates the best pick.
// Depends on tpds_pkg and tpds_divider.
module tpds_cell #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tpds_pkg::item_type in_item,
   output logic               out_valid,
   output tpds_pkg::item_type out_item
);
   import tpds_pkg::*;

   localparam logic [23:0] CLK_HZ = BASE_CLK_HZ >> IDX;
   localparam int          SB_W   = $bits(cell_sb_type);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   item_type    item1_ff, item2_ff;
   logic        small1_ff, small2_ff;
   logic [27:0] p1_ff, p2_ff;
   logic [7:0]  qe2_ff;
   cell_sb_type sb3_ff, sb3_in;
   item_type    item4_ff, item4_in;

   logic [55:0] prod;
   logic [40:0] est;
   logic [27:0] qm, rmd;
   logic [7:0]  q;
   logic [8:0]  div9;

   logic        d1_valid, d2_valid;
   logic [23:0] m_quo;
   logic [SB_W-1:0] d1_sb, d2_sb;
   logic [19:0] period;
   cell_sb_type sb_d2;
   logic [19:0] excess;

   assign prod = {32'd0, CLK_HZ} * {24'd0, in_item.t};
   assign est  = {13'd0, p1_ff} * {28'd0, RECIP_US};
   assign qm   = {20'd0, qe2_ff} * {8'd0, US_PER_S};
   assign rmd  = p2_ff - qm;
   assign q    = (rmd >= {8'd0, US_PER_S}) ? qe2_ff + 8'd1 : qe2_ff;
   assign div9 = {1'b0, q} + 9'd1;

   always_comb begin
      sb3_in.item = item2_ff;
      sb3_in.div  = div9[7:0];
      sb3_in.ok   = small2_ff && ({15'd0, div9} <= CLK_HZ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff  <= in_item;
         small1_ff <= (prod < {28'd0, PROD_LIMIT});
         p1_ff     <= prod[27:0];
         item2_ff  <= item1_ff;
         small2_ff <= small1_ff;
         p2_ff     <= p1_ff;
         qe2_ff    <= est[39:32];
         sb3_ff    <= sb3_in;
         item4_ff  <= item4_in;
      end
   end

   tpds_divider #(
      .NUM_W (24),
      .DEN_W (8),
      .SPS   (DIV_STEPS),
      .SB_W  (SB_W)
   ) u_clk_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_num    (CLK_HZ),
      .in_den    (sb3_ff.div),
      .in_sb     (SB_W'(sb3_ff)),
      .out_valid (d1_valid),
      .out_quo   (m_quo),
      .out_sb    (d1_sb)
   );

   tpds_divider #(
      .NUM_W (20),
      .DEN_W (24),
      .SPS   (DIV_STEPS),
      .SB_W  (SB_W)
   ) u_period_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .in_num    (US_PER_S),
      .in_den    (m_quo),
      .in_sb     (d1_sb),
      .out_valid (d2_valid),
      .out_quo   (period),
      .out_sb    (d2_sb)
   );

   assign sb_d2  = cell_sb_type'(d2_sb);
   assign excess = period - sb_d2.item.t[19:0];

   always_comb begin
      item4_in = sb_d2.item;
      if (sb_d2.ok && ({12'd0, period} >= sb_d2.item.t)) begin
         if (!sb_d2.item.best.found || (excess < sb_d2.item.best.excess)) begin
            item4_in.best.found  = 1'b1;
            item4_in.best.exp    = 5'(IDX);
            item4_in.best.div    = sb_d2.div;
            item4_in.best.excess = excess;
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = item4_ff;

endmodule

>>> src/timer_prescaler_divisor_search.sv
// Top level of the timer prescaler and divisor search: a chain of prescaler cells.
// Depends on tpds_pkg and tpds_cell.
//
// A timeout in microseconds enters on the req_ channel; each transfer yields exactly
// one result on the rsp_ channel carrying the chosen prescaler exponent, the reload
// divisor and a found flag (exponent and divisor are zero when nothing fits).
// One cell per prescaler exponent works on the item in turn; each cell holds a
// multiply and reciprocal stage, a clock-by-divisor divider, a period divider and
// a compare stage. Throughput is one item per cycle while the receiver does not
// stall; the cells take new items every cycle in which the chain is not frozen.
// When the receiver stalls while a result is held, the whole chain freezes and
// req_stall rises; as soon as the result is taken the chain moves again.
// Reset clears all valid bits; no item is in flight afterward and the block
// is ready at once.
module timer_prescaler_divisor_search #(
   parameter int NUM_PRESCALERS = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_timeout_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_prescaler_exp,
   output logic [7:0]  rsp_reload_divisor,
   output logic        rsp_found
);
   import tpds_pkg::*;

   logic     en;
   logic     link_valid [NUM_PRESCALERS+1];
   item_type link_item  [NUM_PRESCALERS+1];
   logic     rsp_valid_ff;
   best_type rsp_best_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_comb begin
      link_valid[0]     = req_valid;
      link_item[0].t    = req_timeout_us;
      link_item[0].best = '0;
   end

   for (genvar i = 0; i < NUM_PRESCALERS; i++) begin : g_cell
      tpds_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (link_valid[i]),
         .in_item   (link_item[i]),
         .out_valid (link_valid[i+1]),
         .out_item  (link_item[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= link_valid[NUM_PRESCALERS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_best_ff <= link_item[NUM_PRESCALERS].best;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prescaler_exp  = rsp_best_ff.exp;
   assign rsp_reload_divisor = rsp_best_ff.div;
   assign rsp_found          = rsp_best_ff.found;

endmodule

>>> test/tb_top.sv
// Testbench for timer_prescaler_divisor_search: drives timeouts and checks each result
// against a behavioral search over all prescalers. Depends only on the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_PRESCALERS = 21;
   localparam longint BASE_CLK = 13560000;
   localparam longint USEC = 1000000;
   localparam int LATENCY = 15 * NUM_PRESCALERS + 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [4:0] exp;
      logic [7:0] div;
      logic       found;
   } setting_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_timeout_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_prescaler_exp;
   logic [7:0]  rsp_reload_divisor;
   logic        rsp_found;
   logic        req_taken = 1'b0;

   logic [31:0] pending_timeouts[$];
   setting_type expected_settings[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          errors = 0;
   int          found_count = 0;
   int          result_count = 0;
   longint      cycle_count = 0;

   timer_prescaler_divisor_search #(.NUM_PRESCALERS(NUM_PRESCALERS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_timeout_us(req_timeout_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_prescaler_exp(rsp_prescaler_exp), .rsp_reload_divisor(rsp_reload_divisor),
      .rsp_found(rsp_found)
   );

   always #5 clock = ~clock;

   function automatic setting_type best_setting(logic [31:0] timeout);
      setting_type best;
      longint t, clk, div, period, excess, best_excess;
      t = timeout;
      best = '0;
      best_excess = 0;
      for (int i = 0; i < NUM_PRESCALERS; i++) begin
         clk = BASE_CLK >> i;
         if (clk == 0) continue;
         div = (clk * t) / USEC + 1;
         if (div > 255 || div > clk) continue;
         period = USEC / (clk / div);
         if (period < t) continue;
         excess = period - t;
         if (!best.found || excess < best_excess) begin
            best.found = 1'b1;
            best.exp = i[4:0];
            best.div = div[7:0];
            best_excess = excess;
         end
      end
      return best;
   endfunction

   // Driver: a transfer completes at a rising edge with valid high and stall low.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_timeouts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_timeout_us <= pending_timeouts.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_settings.push_back(best_setting(req_timeout_us));
      if (!reset && rsp_valid && !rsp_stall) begin
         setting_type want;
         result_count <= result_count + 1;
         if (expected_settings.size() == 0) begin
            $display("%0t: unexpected transfer exp=%0d div=%0d found=%0b", $time,
                     rsp_prescaler_exp, rsp_reload_divisor, rsp_found);
            errors <= errors + 1;
         end else begin
            want = expected_settings.pop_front();
            if (want.found) found_count <= found_count + 1;
            if (rsp_prescaler_exp !== want.exp || rsp_reload_divisor !== want.div
                || rsp_found !== want.found) begin
               $display("%0t: mismatch expected exp=%0d div=%0d found=%0b",
                        $time, want.exp, want.div, want.found,
                        " actual exp=%0d div=%0d found=%0b",
                        rsp_prescaler_exp, rsp_reload_divisor, rsp_found);
               errors <= errors + 1;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_timeouts.size() > 0 || req_valid || expected_settings.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] directed[$];
      logic [31:0] value;
      int sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      directed = '{32'd0, 32'd1, 32'd2, 32'd18, 32'd19, 32'd100, 32'd1000, 32'd4836,
                   32'd10000, 32'd123456, 32'd999999, 32'd1000000, 32'd1000001,
                   32'hffffffff, 32'h80000000, 32'h55555555, 32'haaaaaaaa, 32'h7fffffff,
                   32'd500000, 32'd38000};
      foreach (directed[k]) pending_timeouts.push_back(directed[k]);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 66 : 0;
         recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 38 : 0;
         for (int n = 0; n < 250; n++) begin
            sel = $urandom_range(9);
            if (sel < 6) value = $urandom_range(1000000);
            else if (sel < 8) value = $urandom_range(2000);
            else value = $urandom;
            pending_timeouts.push_back(value);
         end
         wait_drained();
      end
      repeat (LATENCY + 10) @(posedge clock);
      $display("Covered %0d results, %0d with a fitting setting, under three idle patterns.",
               result_count, found_count);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit.");
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
